// ===== src/hsb_pkg.sv =====
// Shared types and constants for the heightmap sculpt brush.
`timescale 1ns / 1ps
package hsb_pkg;

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_STAMP = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // Brush modes.
   typedef enum logic [1:0] {
      MODE_RAISE   = 2'd0,
      MODE_LOWER   = 2'd1,
      MODE_SMOOTH  = 2'd2,
      MODE_FLATTEN = 2'd3
   } mode_type;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MODE     = 2'd0;
   localparam logic [1:0] CSR_RADIUS   = 2'd1;
   localparam logic [1:0] CSR_STRENGTH = 2'd2;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_SQRT = 2'd1,
      ALU_DIV  = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic        go;
      alu_op_type  op;
      logic [47:0] opa;
      logic [27:0] opb;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] value;
   } alu_rsp_type;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECODE,
      ST_RD_CAP,
      ST_LAT_CAP,
      ST_CELL_CHK,
      ST_SQRT,
      ST_RDIV,
      ST_MUL_UU,
      ST_MUL_PT,
      ST_MUL_TS,
      ST_H_CAP,
      ST_NB_ISSUE,
      ST_NB_CAP,
      ST_NB_DONE,
      ST_MUL_MAG,
      ST_DDIV,
      ST_WRITE,
      ST_NEXT,
      ST_RESP
   } state_type;

   localparam int H_W       = 24;
   localparam int CW        = 10;
   localparam int SQ_STEPS  = 24;
   localparam int DIV_STEPS = 32;
   localparam logic [10:0] STR_MIN = 11'd20;
   localparam logic [10:0] STR_MAX = 11'd1024;
   localparam logic signed [33:0] H_MAX = 34'sd8388607;
   localparam logic signed [33:0] H_MIN = -34'sd8388608;

endpackage

// ===== src/heightmap_sculpt_brush_top.sv =====
// Top level of the heightmap sculpt brush: sequencer, item registers and height store.
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy stays high until its
// single result has been shown on the rsp_ ports for one cycle with rsp_valid high,
// and the receiver must take it then. A write stores its height in the decode state,
// and a read captures the stored height in a state of its own. A stamp walks every
// cell of the square around its center, one after another, through one shared
// arithmetic unit: each cell inside the radius takes a 24-step square root, a 32-step
// divide and up to four multiplies, and in smooth mode also up to nine neighbor reads
// over the single read port and one more 32-step divide; a cell outside the radius or
// the map is skipped. A full-size stamp covers 33 by 33 cells.
module heightmap_sculpt_brush_top import hsb_pkg::*; #(
   parameter int MAP_WIDTH         = 256,
   parameter int MAP_HEIGHT        = 256,
   parameter int MAX_RADIUS_HALVES = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_operation,
   input  logic [7:0]            req_cell_x,
   input  logic [7:0]            req_cell_y,
   input  logic signed [23:0]    req_height_in,
   input  logic                  req_new_stroke,
   output logic                  rsp_valid,
   output logic signed [23:0]    rsp_height_out,
   output logic [12:0]           rsp_cells_touched,
   output logic                  rsp_saturated,
   input  logic                  csr_write_en,
   input  logic [1:0]            csr_index,
   input  logic [10:0]           csr_write_data
);

   localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
   localparam int AW     = $clog2(DEPTH);
   localparam int RH_MAX = (MAX_RADIUS_HALVES > 63) ? 63 : MAX_RADIUS_HALVES;

   function automatic logic in_map(logic signed [CW-1:0] x, logic signed [CW-1:0] y);
      return !x[CW-1] && !y[CW-1] && (32'(x) < MAP_WIDTH) && (32'(y) < MAP_HEIGHT);
   endfunction

   function automatic logic [AW-1:0] cell_addr(logic signed [CW-1:0] x,
                                               logic signed [CW-1:0] y);
      return AW'(32'(y) * MAP_WIDTH + 32'(x));
   endfunction

   // Configuration registers.
   mode_type   mode_ff;
   logic [5:0] rh_ff;
   logic [10:0] str_ff;
   logic [5:0] rh_wr;
   logic [10:0] str_wr;

   // Sequencer and item registers.
   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   logic [7:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [23:0] hin_ff, hin_in;
   logic       fresh_ff, fresh_in;
   logic       latched_ff, latched_in;
   logic signed [23:0] level_ff, level_in;
   logic signed [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [1:0] nx_ff, nx_in, ny_ff, ny_in;
   logic       pend_ff, pend_in;
   logic [16:0] t_ff, t_in;
   logic [26:0] ts_ff, ts_in;
   logic signed [23:0] h_ff, h_in;
   logic signed [27:0] sum_ff, sum_in;
   logic [3:0] n_ff, n_in;
   logic signed [28:0] diff_ff, diff_in;
   logic [31:0] q_ff, q_in;
   logic [12:0] touched_ff, touched_in;
   logic       sat_ff, sat_in;
   logic signed [23:0] hout_ff, hout_in;

   // Memory and shared unit.
   logic          ram_we;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic [23:0]   ram_wr_data, ram_rd_data;
   alu_cmd_type   alu_cmd;
   alu_rsp_type   alu_rsp;

   // Derived values.
   logic [5:0] r_half;
   logic signed [CW-1:0] cx_s, cy_s, x_lo, x_hi, y_lo, y_hi, dx, dy, qx, qy;
   logic [5:0] dxa, dya;
   logic [12:0] s_val;
   logic        in_radius;
   logic [AW-1:0] c_addr, p_addr, q_addr;
   logic [16:0] ratio_c, u_val;
   logic [17:0] tm_val;
   logic [60:0] rnd_sum;
   logic [31:0] qd_val;
   logic [27:0] mag;
   logic signed [28:0] nh_prod;
   logic signed [33:0] dq, nh;
   logic signed [23:0] nh_sat;
   logic        nh_clip;
   logic        alu_step;

   hsb_ram #(.WIDTH(H_W), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hsb_alu u_alu (
      .clock (clock),
      .reset (reset),
      .cmd   (alu_cmd),
      .rsp   (alu_rsp)
   );

   // Clamp incoming register values.
   always_comb begin
      rh_wr = csr_write_data[5:0];
      if (rh_wr == 6'd0) begin
         rh_wr = 6'd1;
      end else if (rh_wr > 6'(RH_MAX)) begin
         rh_wr = 6'(RH_MAX);
      end
      str_wr = csr_write_data;
      if (str_wr < STR_MIN) begin
         str_wr = STR_MIN;
      end else if (str_wr > STR_MAX) begin
         str_wr = STR_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RAISE;
         rh_ff   <= 6'd6;
         str_ff  <= 11'd358;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:     mode_ff <= mode_type'(csr_write_data[1:0]);
            CSR_RADIUS:   rh_ff   <= rh_wr;
            CSR_STRENGTH: str_ff  <= str_wr;
            default: ;
         endcase
      end
   end

   // Geometry of the current cell and its neighbor.
   assign r_half = 6'((7'(rh_ff) + 7'd1) >> 1);
   assign cx_s   = $signed({2'b00, cx_ff});
   assign cy_s   = $signed({2'b00, cy_ff});
   assign x_lo   = cx_s - $signed({4'b0, r_half});
   assign x_hi   = cx_s + $signed({4'b0, r_half});
   assign y_lo   = cy_s - $signed({4'b0, r_half});
   assign y_hi   = cy_s + $signed({4'b0, r_half});
   assign dx     = px_ff - cx_s;
   assign dy     = py_ff - cy_s;
   assign dxa    = dx[CW-1] ? 6'(-dx) : 6'(dx);
   assign dya    = dy[CW-1] ? 6'(-dy) : 6'(dy);
   assign s_val  = 13'({7'b0, dxa} * {7'b0, dxa}) + 13'({7'b0, dya} * {7'b0, dya});
   assign in_radius = {s_val, 2'b00} <= 15'({9'b0, rh_ff} * {9'b0, rh_ff});
   assign qx     = px_ff + CW'(nx_ff);
   assign qy     = py_ff + CW'(ny_ff);
   assign c_addr = cell_addr(cx_s, cy_s);
   assign p_addr = cell_addr(px_ff, py_ff);
   assign q_addr = cell_addr(qx, qy);

   // Weight and delta arithmetic around the shared unit.
   assign ratio_c = (alu_rsp.value[31:0] > 32'd65536) ? 17'd65536 : alu_rsp.value[16:0];
   assign u_val   = 17'(18'd65536 - {1'b0, ratio_c});
   assign tm_val  = 18'(19'd196608 - {1'b0, u_val, 1'b0});
   assign rnd_sum = {1'b0, alu_rsp.value[59:0]} + (61'(n_ff) << 25);
   assign qd_val  = rnd_sum[57:26];
   assign mag     = diff_ff[28] ? 28'(-diff_ff) : 28'(diff_ff);
   assign nh_prod = $signed({25'b0, n_ff}) * 29'(h_ff);
   assign dq      = diff_ff[28] ? -$signed({2'b00, q_ff}) : $signed({2'b00, q_ff});
   assign nh      = 34'(h_ff) + dq;
   assign nh_clip = (nh > H_MAX) || (nh < H_MIN);
   assign nh_sat  = (nh > H_MAX) ? 24'(H_MAX) : (nh < H_MIN) ? 24'(H_MIN) : 24'(nh);
   assign alu_step = pend_ff && alu_rsp.done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (op_ff)
               OP_READ: state_in = in_map(cx_s, cy_s) ? ST_RD_CAP : ST_RESP;
               OP_STAMP: begin
                  if (!in_map(cx_s, cy_s)) begin
                     state_in = ST_RESP;
                  end else if (mode_ff == MODE_FLATTEN && !(latched_ff && !fresh_ff)) begin
                     state_in = ST_LAT_CAP;
                  end else begin
                     state_in = ST_CELL_CHK;
                  end
               end
               default: state_in = ST_RESP;
            endcase
         end
         ST_RD_CAP:   state_in = ST_RESP;
         ST_LAT_CAP:  state_in = ST_CELL_CHK;
         ST_CELL_CHK: state_in = (in_map(px_ff, py_ff) && in_radius) ? ST_SQRT : ST_NEXT;
         ST_SQRT:     if (alu_step) state_in = ST_RDIV;
         ST_RDIV: begin
            if (alu_step) state_in = (ratio_c == 17'd0) ? ST_MUL_TS : ST_MUL_UU;
         end
         ST_MUL_UU:   if (alu_step) state_in = ST_MUL_PT;
         ST_MUL_PT:   if (alu_step) state_in = ST_MUL_TS;
         ST_MUL_TS:   if (alu_step) state_in = ST_H_CAP;
         ST_H_CAP:    state_in = (mode_ff == MODE_SMOOTH) ? ST_NB_ISSUE : ST_MUL_MAG;
         ST_NB_ISSUE: begin
            priority if (in_map(qx, qy)) begin
               state_in = ST_NB_CAP;
            end else if (nx_ff == 2'sd1 && ny_ff == 2'sd1) begin
               state_in = ST_NB_DONE;
            end else begin
               state_in = ST_NB_ISSUE;
            end
         end
         ST_NB_CAP: begin
            state_in = (nx_ff == 2'sd1 && ny_ff == 2'sd1) ? ST_NB_DONE : ST_NB_ISSUE;
         end
         ST_NB_DONE:  state_in = ST_MUL_MAG;
         ST_MUL_MAG: begin
            if (alu_step) state_in = (n_ff == 4'd1) ? ST_WRITE : ST_DDIV;
         end
         ST_DDIV:     if (alu_step) state_in = ST_WRITE;
         ST_WRITE:    state_in = ST_NEXT;
         ST_NEXT: begin
            state_in = (px_ff == x_hi && py_ff == y_hi) ? ST_RESP : ST_CELL_CHK;
         end
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Register updates, memory access and shared-unit commands.
   always_comb begin
      op_in      = op_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      hin_in     = hin_ff;
      fresh_in   = fresh_ff;
      latched_in = latched_ff;
      level_in   = level_ff;
      px_in      = px_ff;
      py_in      = py_ff;
      nx_in      = nx_ff;
      ny_in      = ny_ff;
      pend_in    = pend_ff;
      t_in       = t_ff;
      ts_in      = ts_ff;
      h_in       = h_ff;
      sum_in     = sum_ff;
      n_in       = n_ff;
      diff_in    = diff_ff;
      q_in       = q_ff;
      touched_in = touched_ff;
      sat_in     = sat_ff;
      hout_in    = hout_ff;
      ram_we      = 1'b0;
      ram_wr_addr = p_addr;
      ram_wr_data = nh_sat;
      ram_rd_addr = p_addr;
      alu_cmd.go  = 1'b0;
      alu_cmd.op  = ALU_MUL;
      alu_cmd.opa = '0;
      alu_cmd.opb = '0;

      // Each shared-unit state issues once, then waits for done.
      if (state_ff == ST_SQRT || state_ff == ST_RDIV || state_ff == ST_MUL_UU ||
          state_ff == ST_MUL_PT || state_ff == ST_MUL_TS || state_ff == ST_MUL_MAG ||
          state_ff == ST_DDIV) begin
         if (!pend_ff) begin
            alu_cmd.go = 1'b1;
            pend_in    = 1'b1;
         end else if (alu_rsp.done) begin
            pend_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in      = op_type'(req_operation);
               cx_in      = req_cell_x;
               cy_in      = req_cell_y;
               hin_in     = req_height_in;
               fresh_in   = req_new_stroke;
               touched_in = '0;
               sat_in     = 1'b0;
               hout_in    = '0;
            end
         end
         ST_DECODE: begin
            ram_rd_addr = c_addr;
            px_in = x_lo;
            py_in = y_lo;
            if (op_ff == OP_WRITE && in_map(cx_s, cy_s)) begin
               ram_we      = 1'b1;
               ram_wr_addr = c_addr;
               ram_wr_data = hin_ff;
            end
            if (op_ff == OP_STAMP && fresh_ff) begin
               latched_in = 1'b0;
            end
         end
         ST_RD_CAP: hout_in = ram_rd_data;
         ST_LAT_CAP: begin
            level_in   = ram_rd_data;
            latched_in = 1'b1;
         end
         ST_SQRT: begin
            alu_cmd.op  = ALU_SQRT;
            alu_cmd.opa = {1'b0, s_val, 34'b0};
         end
         ST_RDIV: begin
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = {16'b0, alu_rsp.value[31:0]};
            alu_cmd.opb = {22'b0, rh_ff};
            if (alu_step) begin
               t_in = 17'd65536;
            end
         end
         ST_MUL_UU: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {31'b0, u_val};
            alu_cmd.opb = {11'b0, u_val};
            if (!pend_ff) t_in = u_val;
         end
         ST_MUL_PT: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {16'b0, alu_rsp.value[31:0]};
            alu_cmd.opb = {10'b0, 18'(19'd196608 - {1'b0, t_ff, 1'b0})};
            if (alu_step) t_in = alu_rsp.value[48:32];
         end
         ST_MUL_TS: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {31'b0, t_ff};
            alu_cmd.opb = {17'b0, str_ff};
            if (alu_step) ts_in = alu_rsp.value[26:0];
         end
         ST_H_CAP: begin
            h_in   = ram_rd_data;
            nx_in  = -2'sd1;
            ny_in  = -2'sd1;
            sum_in = '0;
            n_in   = 4'd1;
            unique case (mode_ff)
               MODE_RAISE:   diff_in = 29'sd256;
               MODE_LOWER:   diff_in = -29'sd256;
               MODE_SMOOTH: begin
                  n_in    = 4'd0;
                  diff_in = '0;
               end
               MODE_FLATTEN: diff_in = 29'(level_ff) - 29'($signed(ram_rd_data));
               default:      diff_in = '0;
            endcase
         end
         ST_NB_ISSUE: begin
            ram_rd_addr = q_addr;
            if (!in_map(qx, qy)) begin
               if (nx_ff == 2'sd1) begin
                  nx_in = -2'sd1;
                  ny_in = ny_ff + 2'sd1;
               end else begin
                  nx_in = nx_ff + 2'sd1;
               end
            end
         end
         ST_NB_CAP: begin
            sum_in = sum_ff + 28'($signed(ram_rd_data));
            n_in   = n_ff + 4'd1;
            if (nx_ff == 2'sd1) begin
               nx_in = -2'sd1;
               ny_in = ny_ff + 2'sd1;
            end else begin
               nx_in = nx_ff + 2'sd1;
            end
         end
         ST_NB_DONE: diff_in = 29'(sum_ff) - nh_prod;
         ST_MUL_MAG: begin
            alu_cmd.op  = ALU_MUL;
            alu_cmd.opa = {20'b0, mag};
            alu_cmd.opb = {1'b0, ts_ff};
            if (alu_step) q_in = qd_val;
         end
         ST_DDIV: begin
            alu_cmd.op  = ALU_DIV;
            alu_cmd.opa = {16'b0, q_ff};
            alu_cmd.opb = {24'b0, n_ff};
            if (alu_step) q_in = alu_rsp.value[31:0];
         end
         ST_WRITE: begin
            ram_we     = 1'b1;
            touched_in = touched_ff + 13'd1;
            sat_in     = sat_ff | nh_clip;
         end
         ST_NEXT: begin
            if (px_ff == x_hi) begin
               px_in = x_lo;
               py_in = py_ff + CW'(1);
            end else begin
               px_in = px_ff + CW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         latched_ff <= 1'b0;
         level_ff   <= '0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         latched_ff <= latched_in;
         level_ff   <= level_in;
         pend_ff    <= pend_in;
      end
      op_ff      <= op_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      hin_ff     <= hin_in;
      fresh_ff   <= fresh_in;
      px_ff      <= px_in;
      py_ff      <= py_in;
      nx_ff      <= nx_in;
      ny_ff      <= ny_in;
      t_ff       <= t_in;
      ts_ff      <= ts_in;
      h_ff       <= h_in;
      sum_ff     <= sum_in;
      n_ff       <= n_in;
      diff_ff    <= diff_in;
      q_ff       <= q_in;
      touched_ff <= touched_in;
      sat_ff     <= sat_in;
      hout_ff    <= hout_in;
   end

   // Result ports.
   assign busy              = state_ff != ST_IDLE;
   assign rsp_valid         = state_ff == ST_RESP;
   assign rsp_height_out    = hout_ff;
   assign rsp_cells_touched = touched_ff;
   assign rsp_saturated     = sat_ff;

endmodule

// ===== src/hsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module hsb_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hsb_alu.sv =====
// Shared arithmetic unit: multiplier with registered result, iterative square root and divider.
`timescale 1ns / 1ps
module hsb_alu import hsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  alu_cmd_type cmd,
   output alu_rsp_type rsp
);

   logic        busy_ff, busy_in;
   alu_op_type  op_ff, op_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [47:0] acc_ff, acc_in;
   logic [63:0] res_ff, res_in;
   logic [47:0] bit_ff, bit_in;
   logic [6:0]  dvs_ff, dvs_in;
   logic        done_ff, done_in;

   logic [59:0] mul_full;
   logic [47:0] trial;
   logic [7:0]  div_sh;
   logic        div_ge;

   assign mul_full = {28'b0, cmd.opa[31:0]} * {32'b0, cmd.opb};
   assign trial    = res_ff[47:0] + bit_ff;
   assign div_sh   = {acc_ff[6:0], res_ff[31]};
   assign div_ge   = div_sh >= {1'b0, dvs_ff};

   // Start an operation or advance the running one by one step.
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (cmd.go) begin
         op_in = cmd.op;
         unique case (cmd.op)
            ALU_MUL: begin
               res_in  = {4'b0, mul_full};
               done_in = 1'b1;
            end
            ALU_SQRT: begin
               busy_in = 1'b1;
               acc_in  = cmd.opa;
               res_in  = '0;
               bit_in  = 48'h1 << 46;
               cnt_in  = 6'(SQ_STEPS);
            end
            ALU_DIV: begin
               busy_in = 1'b1;
               acc_in  = '0;
               res_in  = {32'b0, cmd.opa[31:0]};
               dvs_in  = cmd.opb[6:0];
               cnt_in  = 6'(DIV_STEPS);
            end
            default: begin
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (op_ff == ALU_SQRT) begin
            if (acc_ff >= trial) begin
               acc_in = acc_ff - trial;
               res_in = {16'b0, (res_ff[47:0] >> 1) + bit_ff};
            end else begin
               res_in = {16'b0, res_ff[47:0] >> 1};
            end
            bit_in = bit_ff >> 2;
         end else begin
            acc_in = 48'(div_ge ? div_sh - {1'b0, dvs_ff} : div_sh);
            res_in = {32'b0, res_ff[30:0], div_ge};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= ALU_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

// ===== src/hsb_chk.sv =====
// Port-level checker for the heightmap sculpt brush, bound to the top level.
`timescale 1ns / 1ps
module hsb_chk (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic [1:0]          req_operation,
   input logic                rsp_valid,
   input logic signed [23:0]  rsp_height_out,
   input logic [12:0]         rsp_cells_touched,
   input logic                rsp_saturated
);

   // An accepted item keeps the block busy until its result.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("block not busy after an accepted item");

   // A result only appears while an item is in flight.
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");

   // Exactly one result cycle, after which the block is free again.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result held longer than one cycle");

   // A stamp result never carries a read height.
   a_stamp_no_height: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_cells_touched != 13'd0 || rsp_saturated) |-> rsp_height_out == 24'sd0)
      else $error("stamp result with nonzero height");

   // The operation code is only sampled at acceptance; an idle cycle shows no result.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && req_operation == req_operation |-> !rsp_valid)
      else $error("result while not busy");

endmodule

bind heightmap_sculpt_brush_top hsb_chk u_hsb_chk (.*);

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the heightmap sculpt brush top level.
`timescale 1ns / 1ps
module tb_top;
   import hsb_pkg::*;

   localparam int WATCHDOG_LIMIT = 600000;
   localparam int MAP_W = 256;
   localparam int MAP_H = 256;

   typedef struct {
      logic signed [23:0] height;
      logic [12:0]        touched;
      logic               sat;
   } brush_result_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_operation;
   logic [7:0]         req_cell_x;
   logic [7:0]         req_cell_y;
   logic signed [23:0] req_height_in;
   logic               req_new_stroke;
   logic               rsp_valid;
   logic signed [23:0] rsp_height_out;
   logic [12:0]        rsp_cells_touched;
   logic               rsp_saturated;
   logic               csr_write_en;
   logic [1:0]         csr_index;
   logic [10:0]        csr_write_data;

   // Shadow copy of the map and of the brush settings.
   int            shadow_map [MAP_W*MAP_H];
   bit            cell_loaded [MAP_W*MAP_H];
   int            loaded_cells [$];
   mode_type      cur_mode;
   int            cur_radius;
   int            cur_strength;
   bit            level_held;
   int            held_level;
   brush_result_t pending_results [$];
   int            error_count;
   int            quiet_cycles;
   bit            gaps_on;

   heightmap_sculpt_brush_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_height_in(req_height_in), .req_new_stroke(req_new_stroke),
      .rsp_valid(rsp_valid), .rsp_height_out(rsp_height_out),
      .rsp_cells_touched(rsp_cells_touched), .rsp_saturated(rsp_saturated),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Bitwise integer square root.
   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   // Division rounded to nearest, ties away from zero.
   function automatic longint round_div(longint num, longint den);
      longint unsigned mag;
      longint unsigned q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic bit on_map(longint x, longint y);
      return x >= 0 && y >= 0 && x < MAP_W && y < MAP_H;
   endfunction

   // Applies one brush stamp to the shadow map.
   function automatic void sculpt(longint cx, longint cy, ref int touched, ref bit sat);
      longint r;
      longint x;
      longint y;
      longint s;
      longint h;
      longint delta;
      longint nh;
      longint sum;
      longint n;
      longint unsigned ratio;
      longint unsigned u;
      longint unsigned tm;
      longint unsigned t;
      r = (cur_radius + 1) / 2;
      for (y = cy - r; y <= cy + r; y++) begin
         for (x = cx - r; x <= cx + r; x++) begin
            if (!on_map(x, y)) continue;
            s = (x - cx) * (x - cx) + (y - cy) * (y - cy);
            if (4 * s > cur_radius * cur_radius) continue;
            ratio = int_root(longint'(s) * 4 * (64'd1 << 32)) / cur_radius;
            if (ratio > 65536) ratio = 65536;
            u = 65536 - ratio;
            tm = 3 * 65536 - 2 * u;
            t = ((u * u) * tm) >> 32;
            h = shadow_map[y * MAP_W + x];
            case (cur_mode)
               MODE_RAISE: delta = round_div(longint'(t) * cur_strength, 64'sd1 << 18);
               MODE_LOWER: delta = -round_div(longint'(t) * cur_strength, 64'sd1 << 18);
               MODE_SMOOTH: begin
                  sum = 0;
                  n = 0;
                  for (longint oy = -1; oy <= 1; oy++)
                     for (longint ox = -1; ox <= 1; ox++)
                        if (on_map(x + ox, y + oy)) begin
                           sum += shadow_map[(y + oy) * MAP_W + x + ox];
                           n++;
                        end
                  delta = round_div((sum - n * h) * longint'(t) * cur_strength,
                                    n * (64'sd1 << 26));
               end
               default: delta = round_div((longint'(held_level) - h) * longint'(t)
                                          * cur_strength, 64'sd1 << 26);
            endcase
            nh = h + delta;
            if (nh > 8388607) begin
               nh = 8388607;
               sat = 1'b1;
            end
            if (nh < -8388608) begin
               nh = -8388608;
               sat = 1'b1;
            end
            shadow_map[y * MAP_W + x] = int'(nh);
            touched++;
         end
      end
   endfunction

   // Works out the result of one accepted item and updates the shadow state.
   function automatic brush_result_t predict_item(op_type op, int x, int y, int h, bit ns);
      brush_result_t res;
      int touched;
      bit sat;
      touched = 0;
      sat = 1'b0;
      res.height = '0;
      case (op)
         OP_WRITE: shadow_map[y * MAP_W + x] = h;
         OP_READ: res.height = shadow_map[y * MAP_W + x];
         OP_STAMP: begin
            if (ns) level_held = 1'b0;
            if (cur_mode == MODE_FLATTEN && !level_held) begin
               held_level = shadow_map[y * MAP_W + x];
               level_held = 1'b1;
            end
            sculpt(x, y, touched, sat);
         end
         default: ;
      endcase
      res.touched = touched[12:0];
      res.sat = sat;
      return res;
   endfunction

   // Drives one item and waits for the block to take it.
   task automatic send_item(op_type op, int x, int y, int h, bit ns);
      if (gaps_on)
         while ($urandom_range(99) < 29) begin
            start <= 1'b0;
            @(posedge clock);
         end
      start <= 1'b1;
      req_operation <= op;
      req_cell_x <= x[7:0];
      req_cell_y <= y[7:0];
      req_height_in <= h[23:0];
      req_new_stroke <= ns;
      do @(posedge clock); while (busy !== 1'b0);
      if (op == OP_WRITE && !cell_loaded[y * MAP_W + x]) begin
         cell_loaded[y * MAP_W + x] = 1'b1;
         loaded_cells.push_back(y * MAP_W + x);
      end
      pending_results.push_back(predict_item(op, x, y, h, ns));
   endtask

   // Waits until every expected result has arrived.
   task automatic settle();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int val);
      logic [10:0] v;
      settle();
      v = val[10:0];
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CSR_MODE: cur_mode = mode_type'(v[1:0]);
         CSR_RADIUS: cur_radius = (v[5:0] < 1) ? 1 : (v[5:0] > 32) ? 32 : v[5:0];
         CSR_STRENGTH: cur_strength = (v < 20) ? 20 : (v > 1024) ? 1024 : v;
         default: ;
      endcase
   endtask

   function automatic int random_height();
      case ($urandom_range(3))
         0: return 8388607 - $urandom_range(2000);
         1: return -8388608 + $urandom_range(2000);
         default: return $signed($urandom_range(24'hFFFFFF) << 8) >>> 8;
      endcase
   endfunction

   // Writes the cells a stamp at this center may read: every cell when forced, else
   // only cells that were never written.
   task automatic load_area(int cx, int cy, bit all, int h);
      int r;
      r = (cur_radius + 1) / 2 + 1;
      for (int y = cy - r; y <= cy + r; y++)
         for (int x = cx - r; x <= cx + r; x++)
            if (on_map(x, y) && (all || !cell_loaded[y * MAP_W + x]))
               send_item(OP_WRITE, x, y, all ? h : random_height(), 1'b0);
   endtask

   task automatic stamp_at(int cx, int cy, bit ns);
      load_area(cx, cy, 1'b0, 0);
      send_item(OP_STAMP, cx, cy, random_height(), ns);
   endtask

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      error_count++;
   endtask

   // Compares each result with the oldest expectation.
   always @(posedge clock) begin
      brush_result_t want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("unexpected result, height %0d", rsp_height_out);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_height_out !== want.height)
               report_mismatch("height_out", rsp_height_out, want.height);
            if (rsp_cells_touched !== want.touched)
               report_mismatch("cells_touched", rsp_cells_touched, want.touched);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", rsp_saturated, want.sat);
         end
      end
   end

   // Ends the run when nothing moves for too long.
   always @(posedge clock) begin
      if ((start === 1'b1 && busy === 1'b0) || rsp_valid === 1'b1 || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic test_write_read();
      send_item(OP_WRITE, 0, 0, -8388608, 1'b0);
      send_item(OP_WRITE, 255, 255, 8388607, 1'b1);
      send_item(OP_WRITE, 170, 85, 24'h555555, 1'b0);
      send_item(OP_WRITE, 85, 170, -5592406, 1'b0);
      send_item(OP_READ, 0, 0, 8388607, 1'b1);
      send_item(OP_READ, 255, 255, 0, 1'b0);
      send_item(OP_READ, 170, 85, 0, 1'b0);
      send_item(OP_READ, 85, 170, 0, 1'b0);
      send_item(OP_NONE, 255, 0, -1, 1'b1);
   endtask

   // Saturation at both ends of the height range, with the strongest brush.
   task automatic test_saturation();
      write_csr(CSR_STRENGTH, 2047);
      write_csr(CSR_RADIUS, 4);
      write_csr(CSR_MODE, MODE_RAISE);
      load_area(0, 0, 1'b1, 8388600);
      send_item(OP_STAMP, 0, 0, 0, 1'b0);
      write_csr(CSR_MODE, MODE_LOWER);
      load_area(255, 255, 1'b1, -8388600);
      send_item(OP_STAMP, 255, 255, 0, 1'b0);
      send_item(OP_READ, 255, 255, 0, 1'b0);
   endtask

   task automatic test_smooth_flatten();
      write_csr(CSR_STRENGTH, 0);
      write_csr(CSR_RADIUS, 63);
      write_csr(CSR_RADIUS, 5);
      write_csr(CSR_MODE, MODE_SMOOTH);
      stamp_at(128, 0, 1'b0);
      write_csr(CSR_STRENGTH, 1024);
      stamp_at(120, 120, 1'b0);
      // The first stamp of a stroke latches its level; later ones reuse it.
      write_csr(CSR_MODE, MODE_FLATTEN);
      stamp_at(100, 100, 1'b1);
      stamp_at(103, 101, 1'b0);
      stamp_at(0, 200, 1'b1);
      send_item(OP_READ, 101, 101, 0, 1'b0);
   endtask

   // Smallest radius and the full-size brush.
   task automatic test_radius_extremes();
      write_csr(CSR_MODE, MODE_RAISE);
      write_csr(CSR_RADIUS, 0);
      stamp_at(50, 60, 1'b0);
      write_csr(CSR_RADIUS, 32);
      write_csr(CSR_STRENGTH, 20);
      stamp_at(0, 255, 1'b0);
      stamp_at(200, 40, 1'b0);
   endtask

   task automatic test_random();
      int x;
      int y;
      int pick;
      int idx;
      for (int i = 0; i < 100; i++) begin
         gaps_on = !(i >= 40 && i < 60);
         if ($urandom_range(9) == 0) begin
            write_csr(CSR_MODE, $urandom_range(3));
            write_csr(CSR_RADIUS, ($urandom_range(9) == 0) ? $urandom_range(63)
                                                           : $urandom_range(1, 8));
            write_csr(CSR_STRENGTH, $urandom_range(2047));
         end
         pick = $urandom_range(99);
         if ($urandom_range(4) == 0) begin
            x = $urandom_range(255);
            y = $urandom_range(255);
         end else begin
            x = $urandom_range(110, 140);
            y = $urandom_range(110, 140);
         end
         if (pick < 35) begin
            stamp_at(x, y, $urandom_range(3) == 0);
         end else if (pick < 65) begin
            send_item(OP_WRITE, x, y, random_height(), $urandom_range(1));
         end else if (pick < 90) begin
            idx = loaded_cells[$urandom_range(loaded_cells.size() - 1)];
            send_item(OP_READ, idx % MAP_W, idx / MAP_W, random_height(), $urandom_range(1));
         end else begin
            send_item(OP_NONE, x, y, random_height(), $urandom_range(1));
         end
      end
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_operation = OP_NONE;
      req_cell_x = '0;
      req_cell_y = '0;
      req_height_in = '0;
      req_new_stroke = 1'b0;
      csr_write_en = 1'b0;
      csr_index = CSR_MODE;
      csr_write_data = '0;
      error_count = 0;
      quiet_cycles = 0;
      gaps_on = 1'b1;
      cur_mode = MODE_RAISE;
      cur_radius = 6;
      cur_strength = 358;
      level_held = 1'b0;
      held_level = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_write_read();
      test_saturation();
      test_smooth_flatten();
      test_radius_extremes();
      test_random();

      settle();
      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
